@@ src/bpq_pkg.sv @@
package bpq_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DEB_W   = 10;
	localparam int unsigned PRESS_W = 10;
	localparam int unsigned GAP_W   = 8;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned CDATA_W = 10;

	// qualifier phases
	localparam logic [PHASE_W-1:0] PH_IDLE        = 2'd0;
	localparam logic [PHASE_W-1:0] PH_PRESS_DEB   = 2'd1;
	localparam logic [PHASE_W-1:0] PH_CONFIRMED   = 2'd2;
	localparam logic [PHASE_W-1:0] PH_RELEASE_DEB = 2'd3;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MIN_PRESS = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_EDGE_GAP  = 2'd2;

	localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 10'd50;
	localparam logic [PRESS_W-1:0] MIN_PRESS_RST = 10'd30;
	localparam logic [GAP_W-1:0]   EDGE_GAP_RST  = 8'd5;

	typedef struct packed {
		logic [DEB_W-1:0]   debounce_ms;
		logic [PRESS_W-1:0] min_press_ms;
		logic [GAP_W-1:0]   min_edge_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic               press_valid;
		logic [PHASE_W-1:0] qualifier_state;
	} result_t;

endpackage

@@ src/bpq_cfg_regs.sv @@
module bpq_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bpq_pkg::CIDX_W-1:0]    wr_index,
	input  logic [bpq_pkg::CDATA_W-1:0]   wr_data,
	output bpq_pkg::cfg_t                 cfg
);
	import bpq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= DEBOUNCE_RST;
			cfg_q.min_press_ms    <= MIN_PRESS_RST;
			cfg_q.min_edge_gap_ms <= EDGE_GAP_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_DEBOUNCE:  cfg_q.debounce_ms     <= wr_data[DEB_W-1:0];
				CFG_MIN_PRESS: cfg_q.min_press_ms    <= wr_data[PRESS_W-1:0];
				CFG_EDGE_GAP:  cfg_q.min_edge_gap_ms <= wr_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/bpq_core.sv @@
module bpq_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  bpq_pkg::cfg_t     cfg,
	output bpq_pkg::result_t  result
);
	import bpq_pkg::*;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic               exp_q, exp_d;
	logic               prev_q;
	logic [TIME_W-1:0]  time_q, time_d;
	logic [TIME_W-1:0]  last_q, last_d;
	logic [TIME_W-1:0]  pstart_q, pstart_d;
	logic [DEB_W-1:0]   rem_q, rem_d;
	logic               run_q, run_d;
	logic               valid_d;
	logic [DEB_W-1:0]   reload;
	logic [TIME_W-1:0]  gap_elapsed;
	logic [TIME_W-1:0]  dur;

	assign reload = (cfg.debounce_ms == '0) ? DEB_W'(1) : cfg.debounce_ms;

	always_comb begin
		time_d   = time_q + TIME_W'(1);
		phase_d  = phase_q;
		exp_d    = exp_q;
		last_d   = last_q;
		pstart_d = pstart_q;
		rem_d    = rem_q;
		run_d    = run_q;
		valid_d  = 1'b0;
		dur      = '0;

		// one-shot timer, then level recheck
		if (run_q) begin
			if (rem_q != '0)
				rem_d = rem_q - DEB_W'(1);
			if (rem_d == '0) begin
				run_d = 1'b0;
				case (phase_q)
					PH_PRESS_DEB: begin
						if (!level) begin
							phase_d  = PH_CONFIRMED;
							pstart_d = time_d;
						end else begin
							phase_d = PH_IDLE;
							exp_d   = 1'b1;
						end
					end
					PH_RELEASE_DEB: begin
						if (level) begin
							dur = time_d - pstart_q;
							if (dur >= TIME_W'(cfg.min_press_ms))
								valid_d = 1'b1;
							phase_d = PH_IDLE;
							exp_d   = 1'b1;
						end else begin
							// pressed again: back to confirmed, expect pressed
							phase_d = PH_CONFIRMED;
							exp_d   = 1'b0;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						exp_d   = 1'b1;
					end
				endcase
			end
		end

		gap_elapsed = time_d - last_q;
		if (level != prev_q && gap_elapsed >= TIME_W'(cfg.min_edge_gap_ms)) begin
			last_d = time_d;
			if (level != exp_d) begin
				case (phase_d)
					PH_IDLE: begin
						if (!level) begin
							phase_d = PH_PRESS_DEB;
							exp_d   = 1'b0;
							rem_d   = reload;
							run_d   = 1'b1;
						end
					end
					PH_CONFIRMED: begin
						if (level) begin
							dur = time_d - pstart_d;
							if (dur >= TIME_W'(cfg.min_press_ms)) begin
								phase_d = PH_RELEASE_DEB;
								exp_d   = 1'b1;
								rem_d   = reload;
								run_d   = 1'b1;
							end else begin
								phase_d = PH_IDLE;
								exp_d   = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			exp_q    <= 1'b1;
			prev_q   <= 1'b1;
			time_q   <= '0;
			last_q   <= '0;
			pstart_q <= '0;
			rem_q    <= '0;
			run_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			exp_q    <= exp_d;
			prev_q   <= level;
			time_q   <= time_d;
			last_q   <= last_d;
			pstart_q <= pstart_d;
			rem_q    <= rem_d;
			run_q    <= run_d;
		end
	end

	assign result.press_valid     = valid_d;
	assign result.qualifier_state = phase_d;

	// timer runs exactly while in a debounce phase
	a_timer_phase: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == (phase_q == PH_PRESS_DEB || phase_q == PH_RELEASE_DEB))
		else $error("timer state disagrees with phase");

	a_timer_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> rem_q != '0)
		else $error("running timer holds zero count");

	a_press_release: assert property (@(posedge clk) disable iff (!arst_n)
		(step && valid_d) |-> (phase_q == PH_RELEASE_DEB && phase_d == PH_IDLE))
		else $error("press pulse outside release recheck");

	a_step_time: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> time_q == $past(time_q) + TIME_W'(1))
		else $error("time did not advance on tick");

endmodule

@@ src/button_press_qualifier.sv @@
// channel  | dir | handshake              | word
// ---------+-----+------------------------+---------------------------------
// in       | in  | in_valid / in_ready    | button_level
// out      | out | out_valid / out_ready  | press_valid, qualifier_state
// cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word per clock unless the output stalls: an input register feeds the
// qualifier update, which loads the result register that drives out_valid.
// Rate is set by the combinational state update (32-bit time compares).
// arst_n clears the qualifier to idle, time to zero, registers to defaults.
// A stalled output holds the result; one more word waits in the input
// register, and in_ready drops only when both are full.
module button_press_qualifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         button_level,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         press_valid,
	output logic [bpq_pkg::PHASE_W-1:0]  qualifier_state,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bpq_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [bpq_pkg::CDATA_W-1:0]  cfg_data
);
	import bpq_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_s2;
	logic    vld_s1, lvl_s1;
	logic    vld_s2;
	logic    advance;

	assign cfg_ready = 1'b1;

	bpq_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (advance)
				vld_s2 <= 1'b1;
			else if (out_ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			lvl_s1 <= button_level;
		if (advance)
			res_s2 <= res;
	end

	bpq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (lvl_s1),
		.cfg    (cfg),
		.result (res)
	);

	assign out_valid       = vld_s2;
	assign press_valid     = res_s2.press_valid;
	assign qualifier_state = res_s2.qualifier_state;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !out_ready) |-> !advance)
		else $error("result overwritten while stalled");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && !out_ready))
		else $error("input stalled without back-pressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !advance) |=> vld_s1 && $stable(lvl_s1))
		else $error("held input word lost");

endmodule
